FILE: rtl/psflm_pkg.sv
package psflm_pkg;

    localparam int NODES     = 64;
    localparam int NODE_BITS = $clog2(NODES);
    localparam int TIME_BITS = 32;
    localparam int CNT_BITS  = 32;
    localparam int SUM_BITS  = 48;
    localparam int SRC_BITS  = 7;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WARM_UP      = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESET_OFFSET = 1'd1;

    typedef enum logic {
        S_IDLE,
        S_CALC
    } t_state;

    typedef struct packed {
        logic [CNT_BITS-1:0]  count;
        logic [SUM_BITS-1:0]  delay_sum;
        logic [TIME_BITS-1:0] max_delay;
        logic [CNT_BITS-1:0]  local_count;
        logic [SUM_BITS-1:0]  local_sum;
        logic [TIME_BITS-1:0] last_time;
    } t_entry;

    typedef struct packed {
        logic [CNT_BITS-1:0]  count;
        logic [SUM_BITS-1:0]  delay_sum;
        logic [TIME_BITS-1:0] max_delay;
        logic [SRC_BITS-1:0]  sources;
        logic [CNT_BITS-1:0]  local_count;
    } t_totals;

    // flit attributes captured at the input transfer
    typedef struct packed {
        logic                 take;
        logic                 is_local;
        logic [TIME_BITS-1:0] delay;
        logic [TIME_BITS-1:0] last_time;
    } t_flit;

endpackage

FILE: rtl/psflm_update.sv
module psflm_update (
    input  psflm_pkg::t_flit   i_flit,
    input  logic               i_entry_valid,
    input  psflm_pkg::t_entry  i_entry,
    input  psflm_pkg::t_totals i_totals,
    output psflm_pkg::t_entry  o_entry,
    output psflm_pkg::t_totals o_totals
);

    logic [psflm_pkg::SUM_BITS:0] ent_sum;
    logic [psflm_pkg::SUM_BITS:0] ent_lsum;
    logic [psflm_pkg::SUM_BITS:0] tot_sum;
    logic [psflm_pkg::SUM_BITS-1:0] delay_ext;

    assign delay_ext = {{(psflm_pkg::SUM_BITS - psflm_pkg::TIME_BITS){1'b0}}, i_flit.delay};
    assign ent_sum   = {1'b0, i_entry.delay_sum} + {1'b0, delay_ext};
    assign ent_lsum  = {1'b0, i_entry.local_sum} + {1'b0, delay_ext};
    assign tot_sum   = {1'b0, i_totals.delay_sum} + {1'b0, delay_ext};

    always_comb begin
        o_entry  = i_entry;
        o_totals = i_totals;
        if (i_flit.take) begin
            if (i_entry.count != '1) begin
                o_entry.count = i_entry.count + 1'b1;
            end
            o_entry.delay_sum = ent_sum[psflm_pkg::SUM_BITS] ? '1
                                : ent_sum[psflm_pkg::SUM_BITS-1:0];
            if (i_flit.delay > i_entry.max_delay) begin
                o_entry.max_delay = i_flit.delay;
            end
            o_entry.last_time = i_flit.last_time;

            if (i_totals.count != '1) begin
                o_totals.count = i_totals.count + 1'b1;
            end
            o_totals.delay_sum = tot_sum[psflm_pkg::SUM_BITS] ? '1
                                 : tot_sum[psflm_pkg::SUM_BITS-1:0];
            if (i_flit.delay > i_totals.max_delay) begin
                o_totals.max_delay = i_flit.delay;
            end
            if (!i_entry_valid && (i_totals.sources != '1)) begin
                o_totals.sources = i_totals.sources + 1'b1;
            end

            if (i_flit.is_local) begin
                if (i_entry.local_count != '1) begin
                    o_entry.local_count = i_entry.local_count + 1'b1;
                end
                o_entry.local_sum = ent_lsum[psflm_pkg::SUM_BITS] ? '1
                                    : ent_lsum[psflm_pkg::SUM_BITS-1:0];
                if (i_totals.local_count != '1) begin
                    o_totals.local_count = i_totals.local_count + 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/per_source_flit_latency_monitor.sv
// Flow: a flit transfer registers its attributes and the entry table read;
// update, writeback and result load share the later edge on which the update
// step fires. A new flit is taken only after that step, as set by the
// read-modify-write of the entry table; a stalled result holds the update step.
// Reset: synchronous, clears config, state, totals, the result valid flag and
// the per-entry valid flags; invalid entries read as zero, so the block takes
// flits right after reset.
module per_source_flit_latency_monitor (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [psflm_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [31:0]                           i_cfg_data,

    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [31:0]                           i_arrival_time,
    input  logic [31:0]                           i_send_time,
    input  logic [5:0]                            i_src_node,
    input  logic [3:0]                            i_src_cluster,
    input  logic [3:0]                            i_dst_cluster,

    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic                                  o_counted,
    output logic [31:0]                           o_source_flit_count,
    output logic [47:0]                           o_source_delay_sum,
    output logic [31:0]                           o_source_max_delay,
    output logic [31:0]                           o_source_local_count,
    output logic [47:0]                           o_source_local_delay_sum,
    output logic [31:0]                           o_source_last_time,
    output logic [31:0]                           o_total_flit_count,
    output logic [47:0]                           o_total_delay_sum,
    output logic [31:0]                           o_overall_max_delay,
    output logic [6:0]                            o_sources_seen,
    output logic [31:0]                           o_total_local_count
);

    psflm_pkg::t_state r_state;
    psflm_pkg::t_state n_state;

    logic [31:0] r_warm_up;
    logic [31:0] r_reset_offset;

    logic [psflm_pkg::NODES-1:0]     r_valid;
    logic [psflm_pkg::NODE_BITS-1:0] r_node;
    psflm_pkg::t_flit                r_flit;
    psflm_pkg::t_flit                n_flit;
    psflm_pkg::t_totals              r_totals;
    psflm_pkg::t_totals              upd_totals;

    psflm_pkg::t_entry r_mem [psflm_pkg::NODES];
    psflm_pkg::t_entry r_rd_data;
    psflm_pkg::t_entry cur_entry;
    psflm_pkg::t_entry upd_entry;

    logic [psflm_pkg::NODE_BITS-1:0] rd_addr;
    logic [psflm_pkg::NODE_BITS-1:0] in_node;
    logic [32:0]                     start_time;
    logic                            in_xfer;
    logic                            calc_fire;
    logic                            r_out_valid;
    logic                            r_counted;
    psflm_pkg::t_entry               r_out_entry;
    psflm_pkg::t_totals              r_out_totals;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm_up      <= '0;
            r_reset_offset <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                psflm_pkg::CFG_WARM_UP:      r_warm_up      <= i_cfg_data;
                psflm_pkg::CFG_RESET_OFFSET: r_reset_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psflm_pkg::S_IDLE: if (i_in_valid) n_state = psflm_pkg::S_CALC;
            psflm_pkg::S_CALC: if (calc_fire)  n_state = psflm_pkg::S_IDLE;
            default:           n_state = psflm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == psflm_pkg::S_IDLE);
        calc_fire  = (r_state == psflm_pkg::S_CALC) && (!r_out_valid || i_out_ready);
    end

    assign in_xfer = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psflm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // flit attributes, computed at the input transfer
    assign in_node    = i_src_node[psflm_pkg::NODE_BITS-1:0];
    assign start_time = {1'b0, r_reset_offset} + {1'b0, r_warm_up};

    always_comb begin
        n_flit.take      = ({1'b0, i_arrival_time} >= start_time);
        n_flit.is_local  = (i_src_cluster == i_dst_cluster);
        n_flit.delay     = (i_arrival_time >= i_send_time) ? i_arrival_time - i_send_time
                           : '0;
        n_flit.last_time = i_arrival_time - r_warm_up;
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_node <= in_node;
            r_flit <= n_flit;
        end
    end

    // entry table, read every cycle, written on update
    assign rd_addr = o_in_ready ? in_node : r_node;

    always_ff @(posedge i_clk) begin
        if (calc_fire && r_flit.take) begin
            r_mem[r_node] <= upd_entry;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign cur_entry = r_valid[r_node] ? r_rd_data : '0;

    psflm_update u_update (
        .i_flit        (r_flit),
        .i_entry_valid (r_valid[r_node]),
        .i_entry       (cur_entry),
        .i_totals      (r_totals),
        .o_entry       (upd_entry),
        .o_totals      (upd_totals)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_totals <= '0;
        end else if (calc_fire && r_flit.take) begin
            r_valid[r_node] <= 1'b1;
            r_totals        <= upd_totals;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (calc_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (calc_fire) begin
            r_counted    <= r_flit.take;
            r_out_entry  <= upd_entry;
            r_out_totals <= upd_totals;
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_counted                = r_counted;
    assign o_source_flit_count      = r_out_entry.count;
    assign o_source_delay_sum       = r_out_entry.delay_sum;
    assign o_source_max_delay       = r_out_entry.max_delay;
    assign o_source_local_count     = r_out_entry.local_count;
    assign o_source_local_delay_sum = r_out_entry.local_sum;
    assign o_source_last_time       = r_out_entry.last_time;
    assign o_total_flit_count       = r_out_totals.count;
    assign o_total_delay_sum        = r_out_totals.delay_sum;
    assign o_overall_max_delay      = r_out_totals.max_delay;
    assign o_sources_seen           = r_out_totals.sources;
    assign o_total_local_count      = r_out_totals.local_count;

endmodule
